@@ rtl/core/jps_pkg.sv @@
// Shared types and constants of the Jacobi Poisson stencil sweep.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jps_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int GRID_W     = 11;
	localparam int HSQ_W      = 31;
	localparam int INV_W      = 25;
	localparam int CFG_DATA_W = 31;
	localparam int CFG_IDX_W  = 2;
	localparam int RSUM_W     = 64;
	localparam int PROD_W     = 61;
	localparam int MAG_W      = 60;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

	localparam cfg_idx_t CFG_GRID_SIZE = 2'd0;
	localparam cfg_idx_t CFG_HSQ_Q30   = 2'd1;
	localparam cfg_idx_t CFG_INV_HSQ   = 2'd2;

	// one window column: two rows back, one row back, current row
	typedef struct packed {
		sample_t top;
		sample_t mid;
		sample_t bot;
	} col_t;

	typedef struct packed {
		sample_t upper;
		sample_t middle;
	} line_pair_t;

endpackage

`default_nettype wire

@@ rtl/core/jps_cell.sv @@
// One column cell of the 3x3 window chain; loads its neighbor's column.
// Depends on jps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jps_cell (
	input  wire           clk,
	input  wire           shift_en,
	input  jps_pkg::col_t col_in,
	output jps_pkg::col_t col_out
);
	import jps_pkg::*;

	col_t col_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

`default_nettype wire

@@ rtl/core/jps_line_mem.sv @@
// Two-line store packed into one word per column, registered read.
// Depends on jps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jps_line_mem #(
	parameter int DEPTH = 1026,
	parameter int AW    = 11
) (
	input  wire                 clk,
	input  wire                 rd_en,
	input  wire  [AW-1:0]       rd_addr,
	output jps_pkg::line_pair_t rd_data,
	input  wire                 wr_en,
	input  wire  [AW-1:0]       wr_addr,
	input  jps_pkg::line_pair_t wr_data
);
	import jps_pkg::*;

	line_pair_t mem [DEPTH];
	line_pair_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

@@ rtl/core/jps_resid_sq.sv @@
// Squared residual: (prod - 1.0)^2 as Q32.32, truncated and saturated.
// Two stages: partial products, then combine and scale. Depends on jps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jps_resid_sq #(
	parameter int FRAC_BITS = 30
) (
	input  wire                                 clk,
	input  wire                                 en,
	input  wire  signed [jps_pkg::PROD_W-1:0]   prod,
	output logic [jps_pkg::RSUM_W-1:0]          sq
);
	import jps_pkg::*;

	localparam int EW    = PROD_W + 1;
	localparam int HW    = MAG_W - 32;
	localparam int LHW   = 32 + HW;
	localparam int HHW   = 2 * HW;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int SHIFT = 2 * FRAC_BITS - 32;
	localparam logic signed [EW-1:0] ONE_F = EW'(1) <<< FRAC_BITS;

	logic signed [EW-1:0] e;
	logic [EW-1:0]        mag_full;
	logic [MAG_W-1:0]     mag;
	logic [31:0]          al;
	logic [HW-1:0]        ah;

	logic [63:0]          ll_s4;
	logic [LHW-1:0]       lh_s4;
	logic [HHW-1:0]       hh_s4;

	logic [SQ_W-1:0]      full;
	logic [SQ_W-1:0]      shifted;
	logic [RSUM_W-1:0]    sq_s5;

	always_comb begin
		e        = EW'(prod) - ONE_F;
		mag_full = e[EW-1] ? EW'(-e) : EW'(e);
		mag      = mag_full[MAG_W-1:0];
		al       = mag[31:0];
		ah       = mag[MAG_W-1:32];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s4 <= 64'(al) * 64'(al);
			lh_s4 <= LHW'(al) * LHW'(ah);
			hh_s4 <= HHW'(ah) * HHW'(ah);
		end
	end

	always_comb begin
		full    = SQ_W'(ll_s4) + (SQ_W'(lh_s4) << 33) + (SQ_W'(hh_s4) << 64);
		shifted = full >> SHIFT;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s5 <= (|shifted[SQ_W-1:RSUM_W]) ? {RSUM_W{1'b1}} : shifted[RSUM_W-1:0];
		end
	end

	assign sq = sq_s5;

endmodule

`default_nettype wire

@@ rtl/core/jacobi_poisson_stencil_sweep_core.sv @@
// Jacobi 5-point Poisson stencil sweep, top level. Uses jps_pkg, jps_cell,
// jps_line_mem and jps_resid_sq.
//
// Input: one tile frame of (g+2)x(g+2) signed Q2.30 samples, row-major, on
// sample/in_valid/in_stall. Output: one request per interior point with the
// Jacobi value, the running squared-residual sum (Q32.32, saturating) and
// is_last on the final point. Border points give no request.
// Config: cfg_valid/cfg_ready with cfg_index and cfg_data; write only while
// idle. Writing grid_size restarts the tile.
// Throughput: one sample per cycle while out_stall does not hold the pipeline,
// set by the line store taking one read and one write per cycle and the
// one-column-per-cycle window chain. Path: input register, window chain,
// quotient/product register, the squaring stages, output register.
// Stall: while a result waits under out_stall the whole pipeline holds and
// in_stall is raised.
// Reset: config registers take their defaults, counters and the sum go to zero.
// The line store needs no clearing: every entry that reaches a result is
// written within the tile before it is read.
`timescale 1ns / 1ps
`default_nettype none

module jacobi_poisson_stencil_sweep_core #(
	parameter int MAX_POINTS = 1024,
	parameter int FRAC_BITS  = 30
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  jps_pkg::sample_t                     sample,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	output jps_pkg::sample_t                     new_value,
	output logic [jps_pkg::RSUM_W-1:0]           residual_sum,
	output logic                                 is_last,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  jps_pkg::cfg_idx_t                    cfg_index,
	input  wire  [jps_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import jps_pkg::*;

	localparam int DEPTH = MAX_POINTS + 2;
	localparam int CW    = $clog2(DEPTH);
	localparam int CMPW  = ((CW > GRID_W) ? CW : GRID_W) + 1;
	localparam int WIN   = 3;
	localparam sample_t Q_MAX = 32'sh7fffffff;
	localparam sample_t Q_MIN = 32'sh80000000;

	// config
	logic [GRID_W-1:0] grid_q;
	logic [HSQ_W-1:0]  hsq_q;
	logic [INV_W-1:0]  inv_q;
	logic              cfg_wr;

	// frame position
	logic [CW-1:0]   col_q, row_q;
	logic [CW-1:0]   last_idx;
	logic [CMPW-1:0] g_ext;
	logic [CW-1:0]   side;
	logic            adv, accept;
	logic            emit_pos, last_pos;

	// pipeline
	logic            valid_s1, emit_s1, last_s1;
	sample_t         smp_s1;
	logic [CW-1:0]   col_s1;
	line_pair_t      rd_pair;
	line_pair_t      wr_pair;
	logic            mem_wr_en;

	logic            valid_s2, last_s2;
	col_t            new_col;
	col_t            cin  [WIN];
	col_t            wcol [WIN];

	logic            valid_s3, last_s3;
	sample_t         q_s3;
	logic signed [PROD_W-1:0] prod_s3;
	logic            valid_s4, last_s4;
	sample_t         q_s4;
	logic            valid_s5, last_s5;
	sample_t         q_s5;
	logic [RSUM_W-1:0] sq_s5;

	logic [RSUM_W-1:0] acc_q;
	logic [RSUM_W:0]   sum_w;
	logic [RSUM_W-1:0] sum_sat;

	logic            out_valid_q, is_last_q;
	sample_t         new_value_q;
	logic [RSUM_W-1:0] residual_sum_q;

	// stencil arithmetic
	sample_t                 up, lf, ce, rt, dn;
	logic signed [33:0]      nb;
	logic signed [34:0]      s_sum;
	logic signed [32:0]      q_full;
	sample_t                 q_sat;
	logic signed [34:0]      d;
	logic signed [INV_W:0]   inv_s;
	logic signed [PROD_W-1:0] prod;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		g_ext = CMPW'(grid_q);
		if (g_ext == '0) begin
			side = CW'(1);
		end else if (g_ext > CMPW'(MAX_POINTS)) begin
			side = CW'(MAX_POINTS);
		end else begin
			side = g_ext[CW-1:0];
		end
		last_idx = side + CW'(1);
	end

	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;
	assign accept   = in_valid && adv;
	assign emit_pos = (row_q >= CW'(2)) && (col_q >= CW'(2));
	assign last_pos = (row_q == last_idx) && (col_q == last_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= GRID_W'(1024);
			hsq_q  <= HSQ_W'(1022);
			inv_q  <= INV_W'(1050625);
			col_q  <= '0;
			row_q  <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_index)
					CFG_GRID_SIZE: begin
						grid_q <= cfg_data[GRID_W-1:0];
						col_q  <= '0;
						row_q  <= '0;
					end
					CFG_HSQ_Q30: begin
						hsq_q <= cfg_data[HSQ_W-1:0];
					end
					CFG_INV_HSQ: begin
						inv_q <= cfg_data[INV_W-1:0];
					end
					default: begin
					end
				endcase
			end else if (accept) begin
				if (col_q == last_idx) begin
					col_q <= '0;
					row_q <= (row_q == last_idx) ? '0 : row_q + CW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
		end else begin
			if (cfg_wr && cfg_index == CFG_GRID_SIZE) begin
				acc_q <= '0;
			end else if (adv && valid_s5) begin
				acc_q <= last_s5 ? '0 : sum_sat;
			end
			if (adv) begin
				valid_s1    <= accept;
				valid_s2    <= valid_s1 && emit_s1;
				valid_s3    <= valid_s2;
				valid_s4    <= valid_s3;
				valid_s5    <= valid_s4;
				out_valid_q <= valid_s5;
			end
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			smp_s1  <= sample;
			col_s1  <= col_q;
			emit_s1 <= emit_pos;
			last_s1 <= last_pos;
		end
		if (adv) begin
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			q_s3    <= q_sat;
			prod_s3 <= prod;
			last_s4 <= last_s3;
			q_s4    <= q_s3;
			last_s5 <= last_s4;
			q_s5    <= q_s4;
			if (valid_s5) begin
				new_value_q    <= q_s5;
				residual_sum_q <= sum_sat;
				is_last_q      <= last_s5;
			end
		end
	end

	assign mem_wr_en      = valid_s1 && adv;
	assign wr_pair.upper  = rd_pair.middle;
	assign wr_pair.middle = smp_s1;

	jps_line_mem #(
		.DEPTH(DEPTH),
		.AW   (CW)
	) u_line_mem (
		.clk    (clk),
		.rd_en  (accept),
		.rd_addr(col_q),
		.rd_data(rd_pair),
		.wr_en  (mem_wr_en),
		.wr_addr(col_s1),
		.wr_data(wr_pair)
	);

	assign new_col.top = rd_pair.upper;
	assign new_col.mid = rd_pair.middle;
	assign new_col.bot = smp_s1;

	for (genvar i = 0; i < WIN; i++) begin : g_win
		if (i == WIN - 1) begin : g_head
			assign cin[i] = new_col;
		end else begin : g_link
			assign cin[i] = wcol[i+1];
		end
		jps_cell u_cell (
			.clk     (clk),
			.shift_en(mem_wr_en),
			.col_in  (cin[i]),
			.col_out (wcol[i])
		);
	end

	always_comb begin
		lf     = wcol[0].mid;
		up     = wcol[1].top;
		ce     = wcol[1].mid;
		dn     = wcol[1].bot;
		rt     = wcol[2].mid;
		nb     = 34'(up) + 34'(lf) + 34'(rt) + 34'(dn);
		s_sum  = 35'(signed'({1'b0, hsq_q})) + 35'(nb);
		q_full = 33'(s_sum >>> 2);
		if (q_full > 33'(Q_MAX)) begin
			q_sat = Q_MAX;
		end else if (q_full < 33'(Q_MIN)) begin
			q_sat = Q_MIN;
		end else begin
			q_sat = q_full[31:0];
		end
		d     = (35'(ce) <<< 2) - 35'(nb);
		inv_s = signed'({1'b0, inv_q});
		prod  = PROD_W'(d) * PROD_W'(inv_s);
	end

	jps_resid_sq #(
		.FRAC_BITS(FRAC_BITS)
	) u_resid_sq (
		.clk (clk),
		.en  (adv),
		.prod(prod_s3),
		.sq  (sq_s5)
	);

	always_comb begin
		sum_w   = {1'b0, acc_q} + {1'b0, sq_s5};
		sum_sat = sum_w[RSUM_W] ? {RSUM_W{1'b1}} : sum_w[RSUM_W-1:0];
	end

	assign out_valid    = out_valid_q;
	assign new_value    = new_value_q;
	assign residual_sum = residual_sum_q;
	assign is_last      = is_last_q;

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mem_wr_en) |-> (col_q != col_s1))
		else $error("line store read and write hit the same column");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= last_idx) && (row_q <= last_idx))
		else $error("frame position beyond frame edge");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_last_q) |-> (acc_q == '0))
		else $error("residual sum not cleared with last point");

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_pos && !cfg_wr) |=> (col_q == '0) && (row_q == '0))
		else $error("frame position did not wrap after last sample");

endmodule

`default_nettype wire

@@ verif/tb_jacobi_poisson_stencil_sweep_core.sv @@
// Self-checking testbench for jacobi_poisson_stencil_sweep_core: streams tile frames,
// predicts each Jacobi point and residual sum in a scoreboard class, and checks every result.
// Depends on jps_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_jacobi_poisson_stencil_sweep_core;

	import jps_pkg::*;

	localparam int MAX_POINTS      = 1024;
	localparam int FRAC_BITS       = 30;
	localparam int LINE_DEPTH      = MAX_POINTS + 2;
	localparam int SQ_SHIFT        = 2 * FRAC_BITS - 32;
	localparam int RANDOM_ITEMS    = 860;
	localparam int PARTIAL_RUN     = 30;
	localparam int DRAIN_CYCLES    = 12;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int MAX_REPORTS     = 100;
	localparam longint TIMEOUT_NS  = 64'd10_000_000;

	localparam cfg_idx_t CFG_UNUSED = 2'd3;
	localparam sample_t SAMPLE_MAX  = 32'sh7FFFFFFF;
	localparam sample_t SAMPLE_MIN  = 32'sh80000000;

	typedef enum int {FILL_RANDOM, FILL_SMALL, FILL_CORNER, FILL_NEAR_ONE, FILL_MIXED} fill_e;

	typedef struct {
		sample_t     value;
		logic [63:0] rsum;
		logic        last;
	} point_t;

	class jacobi_scoreboard;
		bit [GRID_W-1:0] grid_reg;
		bit [HSQ_W-1:0]  hsq_reg;
		bit [INV_W-1:0]  inv_reg;
		bit [31:0]       upper_line[LINE_DEPTH];
		bit [31:0]       middle_line[LINE_DEPTH];
		bit [31:0]       win[9];
		int unsigned     row;
		int unsigned     col;
		bit [63:0]       rsum_acc;
		point_t          pending_points[$];
		int              errors;

		function new();
			grid_reg = 11'd1024;
			hsq_reg  = 31'd1022;
			inv_reg  = 25'd1050625;
			row      = 0;
			col      = 0;
			rsum_acc = '0;
			errors   = 0;
		endfunction

		function void apply_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_GRID_SIZE: begin
					grid_reg = data[GRID_W-1:0];
					row      = 0;
					col      = 0;
					rsum_acc = '0;
				end
				CFG_HSQ_Q30: hsq_reg = data[HSQ_W-1:0];
				CFG_INV_HSQ: inv_reg = data[INV_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(sample_t smp);
			int unsigned side, w, c, r;
			longint up, lf, ce, rt, dn, nb, s, q, d, e, hsq_l, inv_l;
			bit [63:0]  mag, sq;
			bit [127:0] sq_full;
			bit [64:0]  acc_sum;
			point_t     pt;
			side = 32'(grid_reg);
			if (side < 1) side = 1;
			if (side > MAX_POINTS) side = MAX_POINTS;
			w = side + 2;
			c = (col >= w) ? w - 1 : col;
			r = (row >= w) ? w - 1 : row;
			for (int k = 0; k < 3; k++) begin
				win[k*3]   = win[k*3+1];
				win[k*3+1] = win[k*3+2];
			end
			win[2] = upper_line[c];
			win[5] = middle_line[c];
			win[8] = smp;
			upper_line[c]  = middle_line[c];
			middle_line[c] = smp;
			if (r >= 2 && c >= 2) begin
				up    = 64'($signed(win[1]));
				lf    = 64'($signed(win[3]));
				ce    = 64'($signed(win[4]));
				rt    = 64'($signed(win[5]));
				dn    = 64'($signed(win[7]));
				hsq_l = 64'(hsq_reg);
				inv_l = 64'(inv_reg);
				nb = up + lf + rt + dn;
				s  = hsq_l + nb;
				q  = s >>> 2;
				if (q > 64'sd2147483647) q = 64'sd2147483647;
				if (q < -64'sd2147483648) q = -64'sd2147483648;
				d   = 4 * ce - nb;
				e   = d * inv_l - (64'sd1 <<< FRAC_BITS);
				mag = (e < 0) ? -e : e;
				sq_full = ({64'd0, mag} * {64'd0, mag}) >> SQ_SHIFT;
				sq      = (sq_full[127:64] != 0) ? '1 : sq_full[63:0];
				acc_sum  = {1'b0, rsum_acc} + {1'b0, sq};
				rsum_acc = acc_sum[64] ? '1 : acc_sum[63:0];
				pt.value = q[31:0];
				pt.rsum  = rsum_acc;
				pt.last  = (r == w - 1) && (c == w - 1);
				pending_points.push_back(pt);
			end
			if (c + 1 >= w) begin
				col = 0;
				if (r + 1 >= w) begin
					row      = 0;
					rsum_acc = '0;
				end else begin
					row = r + 1;
				end
			end else begin
				col = c + 1;
				row = r;
			end
		endfunction

		function void report(string what, logic [63:0] want, logic [63:0] got);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
		endfunction

		function void check_point(sample_t nv, logic [63:0] rs, logic lst);
			point_t pt;
			if (pending_points.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected request, expected none, actual new_value %h",
						$time, nv);
				return;
			end
			pt = pending_points.pop_front();
			if (nv !== pt.value) report("new_value", 64'(unsigned'(pt.value)), 64'(unsigned'(nv)));
			if (rs !== pt.rsum) report("residual_sum", pt.rsum, rs);
			if (lst !== pt.last) report("is_last", 64'(pt.last), 64'(lst));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	sample_t               sample;
	logic                  in_valid;
	logic                  in_stall;
	sample_t               new_value;
	logic [RSUM_W-1:0]     residual_sum;
	logic                  is_last;
	logic                  out_valid;
	logic                  out_stall;
	logic                  cfg_valid;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	jacobi_scoreboard sb = new();
	int in_calm;
	int out_calm;
	bit hold_off_request;

	jacobi_poisson_stencil_sweep_core #(
		.MAX_POINTS(MAX_POINTS),
		.FRAC_BITS (FRAC_BITS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (sample),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.new_value   (new_value),
		.residual_sum(residual_sum),
		.is_last     (is_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle cycles before the next request, with bursts of back-to-back traffic
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) calm = $urandom_range(20, 80);
		return $urandom_range(0, 15);
	endfunction

	function automatic int unsigned frame_len(int unsigned g);
		int unsigned side;
		side = (g < 1) ? 1 : (g > MAX_POINTS) ? MAX_POINTS : g;
		return (side + 2) * (side + 2);
	endfunction

	function automatic sample_t make_sample(fill_e fill);
		sample_t v;
		if (fill == FILL_MIXED) fill = fill_e'($urandom_range(0, 3));
		case (fill)
			FILL_SMALL: begin
				v = $urandom_range(0, 8191);
				v = v - 4096;
			end
			FILL_CORNER: begin
				case ($urandom_range(0, 4))
					0: v = SAMPLE_MAX;
					1: v = SAMPLE_MIN;
					2: v = '0;
					3: v = -1;
					default: v = 32'sd1 <<< FRAC_BITS;
				endcase
			end
			FILL_NEAR_ONE: v = (32'sd1 <<< FRAC_BITS) + $urandom_range(0, 2047) - 1024;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic send_sample(input sample_t v);
		int gap;
		gap = draw_gap(in_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample   <= v;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_sample(v);
	endtask

	task automatic send_run(input int unsigned count, input fill_e fill);
		for (int unsigned i = 0; i < count; i++) send_sample(make_sample(fill));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending_points.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.apply_write(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int gap;
		forever begin
			gap = draw_gap(out_calm);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				gap = HOLD_OFF_CYCLES;
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			sb.check_point(new_value, residual_sum, is_last);
		end
	end

	initial begin
		int unsigned random_items, n, g, phase_no, tiles;
		logic [CFG_DATA_W-1:0] hsq_val, inv_val;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		sample    <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_GRID_SIZE;
		cfg_data  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults, full-size frame: part of the first row, no points
		send_run(PARTIAL_RUN, FILL_MIXED);
		wait_idle();

		// grid 0 runs as 1; all samples at max saturate the quotient
		cfg_write(CFG_GRID_SIZE, '0);
		cfg_write(CFG_HSQ_Q30, 31'd1 << FRAC_BITS);
		cfg_write(CFG_INV_HSQ, 31'h1FFFFFF);
		repeat (9) send_sample(SAMPLE_MAX);
		wait_idle();

		// unknown index ignored; hsq beyond range, inv_hsq of zero
		cfg_write(CFG_UNUSED, '1);
		cfg_write(CFG_GRID_SIZE, 31'd1);
		cfg_write(CFG_HSQ_Q30, 31'h7FFFFFFF);
		cfg_write(CFG_INV_HSQ, '0);
		repeat (9) send_sample(SAMPLE_MIN);
		wait_idle();

		cfg_write(CFG_HSQ_Q30, '0);
		cfg_write(CFG_INV_HSQ, 31'd1);
		for (int i = 0; i < 9; i++) send_sample((i == 4) ? SAMPLE_MIN : SAMPLE_MAX);
		wait_idle();

		// grid above the limit runs as the limit: part of the first row, no points
		cfg_write(CFG_GRID_SIZE, 31'h7FF);
		cfg_write(CFG_HSQ_Q30, CFG_DATA_W'($urandom_range(0, 1 << FRAC_BITS)));
		cfg_write(CFG_INV_HSQ, CFG_DATA_W'($urandom_range(1, 1 << 24)));
		send_run(PARTIAL_RUN, FILL_MIXED);
		wait_idle();

		random_items = 0;
		phase_no     = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (phase_no == 3) hold_off_request = 1'b1;
			case ($urandom_range(0, 19))
				0: g = 0;
				1: g = $urandom_range(9, 16);
				default: g = $urandom_range(1, 8);
			endcase
			cfg_write(CFG_GRID_SIZE, CFG_DATA_W'(g));
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 3))
					0: hsq_val = CFG_DATA_W'($urandom_range(0, 1 << FRAC_BITS));
					1: hsq_val = CFG_DATA_W'($urandom);
					2: hsq_val = 31'd1 << FRAC_BITS;
					default: hsq_val = CFG_DATA_W'($urandom_range(0, 4095));
				endcase
				cfg_write(CFG_HSQ_Q30, hsq_val);
			end
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 4))
					0: inv_val = CFG_DATA_W'($urandom_range(1, 1 << 24));
					1: inv_val = CFG_DATA_W'($urandom & 32'h1FFFFFF);
					2: inv_val = CFG_DATA_W'($urandom_range(1, 64));
					3: inv_val = 31'd1050625;
					default: inv_val = '0;
				endcase
				cfg_write(CFG_INV_HSQ, inv_val);
			end
			if ($urandom_range(0, 9) == 0) cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));
			tiles = $urandom_range(1, 3);
			n = tiles * frame_len(g);
			// truncated tile, restarted by the next grid_size write
			if ($urandom_range(0, 5) == 0) n += $urandom_range(1, frame_len(g) - 1);
			if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
			send_run(n, fill_e'($urandom_range(0, 4)));
			random_items += n;
			phase_no++;
			wait_idle();
		end

		if (sb.errors == 0 && sb.pending_points.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAILURE");
		$finish;
	end

endmodule
